### hdl/assert_macros.svh
// Assertion macros shared by the torch height control RTL.
// Each macro checks one property on the rising clock edge, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must never be true.
`define PTC_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define PTC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### hdl/ptc_pkg.sv
// Types and constants for the plasma torch height control block.
// No dependencies; the other modules and the testbench refer to it by scoped names.
package ptc_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int DLY_W = 15;
    localparam int CMP_W = ((TIMER_WIDTH > DLY_W) ? TIMER_WIDTH : DLY_W) + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int VOLT_W = 10;
    localparam int PROD_W = 26;

    localparam logic [VOLT_W-1:0] SEG1_LIMIT = 10'd403;
    localparam logic [VOLT_W-1:0] SEG2_LIMIT = 10'd830;
    localparam logic [PROD_W-1:0] SEG1_OFS = 26'd44125389;
    localparam logic [PROD_W-1:0] SEG2_OFS = 26'd24614207;
    localparam logic [PROD_W-1:0] SEG3_OFS = 26'd27629978;
    localparam logic [16:0] SEG1_SLOPE = 17'd70462;
    localparam logic [16:0] SEG2_SLOPE = 17'd22050;
    localparam logic [16:0] SEG3_SLOPE = 17'd25369;
    localparam logic [VOLT_W-1:0] MIN_VOLTS = 10'd70;
    localparam logic [DLY_W-1:0] MS_PER_TENTH = 15'd100;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_VOLTAGE = 3'd0,
        CFG_START_DELAY    = 3'd1,
        CFG_POST_DELAY     = 3'd2,
        CFG_HYSTERESIS     = 3'd3,
        CFG_WINDOW_LOW     = 3'd4,
        CFG_WINDOW_HIGH    = 3'd5,
        CFG_REFRESH_DROP   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] elapsed_ms;
        logic [9:0] adc_sample;
        logic       torch_pin;
        logic       arc_pin;
        logic       estop_pin;
    } t_in_item;

    typedef struct packed {
        logic       torch_drive;
        logic       arc_ok;
        logic       move_up;
        logic       move_down;
        logic       estop_active;
        logic [9:0] arc_volts;
        logic       arc_detected;
    } t_out_item;

    typedef struct packed {
        logic [7:0]        elapsed_ms;
        logic [VOLT_W-1:0] volts;
        logic              torch_pin;
        logic              arc_pin;
        logic              estop_pin;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic [9:0] target_voltage;
        logic [7:0] start_delay_tenths;
        logic [7:0] post_delay_tenths;
        logic [7:0] hysteresis_volts;
        logic [9:0] arc_window_low;
        logic [9:0] arc_window_high;
        logic [7:0] refresh_drop;
    } t_cfg;

endpackage

### hdl/plasma_torch_height_control.sv
// Top level of the plasma torch height control block.
// Depends on ptc_pkg, ptc_front, ptc_queue, ptc_back and assert_macros.svh.
//
// Each input item is one control pass: elapsed milliseconds, a raw ADC arc
// voltage sample and the torch, arc and e-stop pin levels. Each item yields
// exactly one result item with the torch, arc-ok, up, down and e-stop outputs,
// the stored arc voltage and the arc flag.
// Both item channels use valid/ready. The front end converts the sample to
// volts and writes a two-entry queue; the back end updates the control state
// and loads a result register. A result passes through a queue entry and the
// result register; one item per cycle is sustained while the receiver takes
// results, as the back end updates its state for each item that it pops.
// When the receiver stalls, the result register holds, the queue fills, and
// input ready drops once both queue entries are occupied. Users must write
// registers through the write port while the block is idle (not enforced).
// Synchronous reset empties the queue and the result register, loads the
// register defaults and clears the control state.
`include "assert_macros.svh"

module plasma_torch_height_control (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ptc_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ptc_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    ptc_pkg::t_cfg      r_cfg;
    ptc_pkg::t_cmd      push_cmd;
    ptc_pkg::t_cmd      head_cmd;
    ptc_pkg::t_q_status q_status;
    logic               push;
    logic               pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_voltage     <= 10'd140;
            r_cfg.start_delay_tenths <= 8'd10;
            r_cfg.post_delay_tenths  <= 8'd10;
            r_cfg.hysteresis_volts   <= 8'd3;
            r_cfg.arc_window_low     <= 10'd50;
            r_cfg.arc_window_high    <= 10'd250;
            r_cfg.refresh_drop       <= 8'd2;
        end else if (i_cfg_we) begin
            case (ptc_pkg::t_cfg_idx'(i_cfg_index))
                ptc_pkg::CFG_TARGET_VOLTAGE: begin
                    r_cfg.target_voltage <= i_cfg_wdata;
                end
                ptc_pkg::CFG_START_DELAY: begin
                    r_cfg.start_delay_tenths <= i_cfg_wdata[7:0];
                end
                ptc_pkg::CFG_POST_DELAY: begin
                    r_cfg.post_delay_tenths <= i_cfg_wdata[7:0];
                end
                ptc_pkg::CFG_HYSTERESIS: begin
                    r_cfg.hysteresis_volts <= i_cfg_wdata[7:0];
                end
                ptc_pkg::CFG_WINDOW_LOW: begin
                    r_cfg.arc_window_low <= i_cfg_wdata;
                end
                ptc_pkg::CFG_WINDOW_HIGH: begin
                    r_cfg.arc_window_high <= i_cfg_wdata;
                end
                ptc_pkg::CFG_REFRESH_DROP: begin
                    r_cfg.refresh_drop <= i_cfg_wdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    ptc_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    ptc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    ptc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head_cmd),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    `PTC_ASSERT_NEVER(a_up_and_down, i_clk, i_rst_n, o_out_valid && o_out_item.move_up && o_out_item.move_down)
    `PTC_ASSERT_IMPLIES(a_estop_quiet, i_clk, i_rst_n, o_out_valid && o_out_item.estop_active, !o_out_item.torch_drive && !o_out_item.arc_ok && !o_out_item.move_up && !o_out_item.move_down)
    `PTC_ASSERT_IMPLIES(a_move_needs_ok, i_clk, i_rst_n, o_out_valid && (o_out_item.move_up || o_out_item.move_down), o_out_item.arc_ok)
    `PTC_ASSERT_IMPLIES(a_ok_needs_arc, i_clk, i_rst_n, o_out_valid && o_out_item.arc_ok, o_out_item.arc_detected && o_out_item.torch_drive)

endmodule

### hdl/ptc_front.sv
// Front end: accepts input items and converts the ADC sample to volts.
// Depends on ptc_pkg; feeds ptc_queue.
module ptc_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ptc_pkg::t_in_item i_in_item,
    input  ptc_pkg::t_q_status i_q_status,
    output logic              o_push,
    output ptc_pkg::t_cmd     o_cmd
);

    logic [ptc_pkg::PROD_W-1:0] ofs;
    logic [16:0]                slope;
    logic [ptc_pkg::PROD_W-1:0] prod;
    logic [ptc_pkg::PROD_W-1:0] diff;
    logic [ptc_pkg::VOLT_W-1:0] volts;

    always_comb begin
        if (i_in_item.adc_sample < ptc_pkg::SEG1_LIMIT) begin
            ofs   = ptc_pkg::SEG1_OFS;
            slope = ptc_pkg::SEG1_SLOPE;
        end else if (i_in_item.adc_sample < ptc_pkg::SEG2_LIMIT) begin
            ofs   = ptc_pkg::SEG2_OFS;
            slope = ptc_pkg::SEG2_SLOPE;
        end else begin
            ofs   = ptc_pkg::SEG3_OFS;
            slope = ptc_pkg::SEG3_SLOPE;
        end
        prod = ptc_pkg::PROD_W'({9'd0, slope} * {16'd0, i_in_item.adc_sample});
        diff = ofs - prod;
        if (prod >= ofs) begin
            volts = '0;
        end else begin
            volts = diff[ptc_pkg::PROD_W-1:16];
        end
        if (volts < ptc_pkg::MIN_VOLTS) begin
            volts = '0;
        end
    end

    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    always_comb begin
        o_cmd.elapsed_ms = i_in_item.elapsed_ms;
        o_cmd.volts      = volts;
        o_cmd.torch_pin  = i_in_item.torch_pin;
        o_cmd.arc_pin    = i_in_item.arc_pin;
        o_cmd.estop_pin  = i_in_item.estop_pin;
    end

endmodule

### hdl/ptc_queue.sv
// Short queue between the front end and the control back end.
// Depends on ptc_pkg for the entry type and depth.
module ptc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ptc_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output ptc_pkg::t_cmd      o_head,
    output ptc_pkg::t_q_status o_status
);

    ptc_pkg::t_cmd                r_mem [ptc_pkg::QUEUE_DEPTH];
    logic [ptc_pkg::PTR_W-1:0]    r_wr_ptr;
    logic [ptc_pkg::PTR_W-1:0]    r_rd_ptr;
    logic [ptc_pkg::CNT_W-1:0]    r_count;
    logic [ptc_pkg::PTR_W-1:0]    n_wr_ptr;
    logic [ptc_pkg::PTR_W-1:0]    n_rd_ptr;
    logic [ptc_pkg::CNT_W-1:0]    n_count;

    localparam logic [ptc_pkg::PTR_W-1:0] LAST = ptc_pkg::PTR_W'(ptc_pkg::QUEUE_DEPTH - 1);
    localparam logic [ptc_pkg::CNT_W-1:0] FULL = ptc_pkg::CNT_W'(ptc_pkg::QUEUE_DEPTH);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == FULL);

endmodule

### hdl/ptc_back.sv
// Back end: arc detection, delay timing and height regulation state.
// Depends on ptc_pkg; drains ptc_queue into a registered result stage.
module ptc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptc_pkg::t_cfg      i_cfg,
    input  ptc_pkg::t_cmd      i_head,
    input  ptc_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ptc_pkg::t_out_item o_out_item
);

    logic [ptc_pkg::TIMER_WIDTH-1:0] r_timer;
    logic                            r_arc_pin_last;
    logic                            r_arc_present;
    logic                            r_arc_from_pin;
    logic                            r_delay_pending;
    logic                            r_arc_ok;
    logic                            r_up;
    logic                            r_down;
    logic                            r_torch_out;
    logic [ptc_pkg::VOLT_W-1:0]      r_voltage;
    logic                            r_out_valid;
    ptc_pkg::t_out_item              r_out_item;

    logic [ptc_pkg::TIMER_WIDTH-1:0] n_timer;
    logic                            n_arc_present;
    logic                            n_arc_from_pin;
    logic                            n_delay_pending;
    logic                            n_arc_ok;
    logic                            n_up;
    logic                            n_down;
    logic                            n_torch_out;
    logic [ptc_pkg::VOLT_W-1:0]      n_voltage;

    logic [ptc_pkg::TIMER_WIDTH:0]   tsum;
    logic [ptc_pkg::CMP_W-1:0]       timer_x;
    logic [ptc_pkg::CMP_W-1:0]       start_ms;
    logic [ptc_pkg::CMP_W-1:0]       post_ms;
    logic [ptc_pkg::VOLT_W-1:0]      vdrop;
    logic signed [11:0]              band_hi;
    logic signed [11:0]              band_lo;
    logic signed [11:0]              v_s;

    assign o_pop = !i_q_status.empty && (!r_out_valid || i_out_ready);

    assign start_ms = ptc_pkg::CMP_W'({7'd0, i_cfg.start_delay_tenths} * ptc_pkg::MS_PER_TENTH);
    assign post_ms  = ptc_pkg::CMP_W'({7'd0, i_cfg.post_delay_tenths} * ptc_pkg::MS_PER_TENTH);
    assign band_hi  = $signed({2'b00, i_cfg.target_voltage})
                    + $signed({4'd0, i_cfg.hysteresis_volts});
    assign band_lo  = $signed({2'b00, i_cfg.target_voltage})
                    - $signed({4'd0, i_cfg.hysteresis_volts});

    always_comb begin
        tsum = {1'b0, r_timer}
             + {{(ptc_pkg::TIMER_WIDTH + 1 - 8){1'b0}}, i_head.elapsed_ms};
        n_timer = tsum[ptc_pkg::TIMER_WIDTH] ? '1 : tsum[ptc_pkg::TIMER_WIDTH-1:0];
        n_arc_present   = r_arc_present;
        n_arc_from_pin  = r_arc_from_pin;
        n_delay_pending = r_delay_pending;
        n_arc_ok        = r_arc_ok;
        n_up            = r_up;
        n_down          = r_down;
        n_torch_out     = r_torch_out;

        if (i_head.arc_pin != r_arc_pin_last) begin
            if (i_head.arc_pin) begin
                n_arc_present   = 1'b0;
                n_arc_from_pin  = 1'b0;
                n_delay_pending = 1'b0;
            end else if (i_head.torch_pin) begin
                n_arc_present   = 1'b1;
                n_arc_from_pin  = 1'b1;
                n_delay_pending = 1'b1;
                n_timer         = '0;
            end
        end

        vdrop     = r_voltage - i_head.volts;
        n_voltage = r_voltage;
        if (i_head.volts > r_voltage || vdrop > {2'b00, i_cfg.refresh_drop}) begin
            n_voltage = i_head.volts;
        end
        v_s = $signed({2'b00, n_voltage});

        if (!i_head.estop_pin) begin
            n_torch_out = i_head.torch_pin;
            if (!n_arc_from_pin && i_head.torch_pin) begin
                if (n_voltage >= i_cfg.arc_window_low && n_voltage <= i_cfg.arc_window_high) begin
                    if (!n_arc_present) begin
                        n_arc_present   = 1'b1;
                        n_delay_pending = 1'b1;
                        n_timer         = '0;
                    end
                end else if (n_arc_present) begin
                    n_arc_present   = 1'b0;
                    n_delay_pending = 1'b0;
                end
            end
            timer_x = {{(ptc_pkg::CMP_W - ptc_pkg::TIMER_WIDTH){1'b0}}, n_timer};
            if (n_delay_pending && timer_x > start_ms) begin
                n_delay_pending = 1'b0;
                n_arc_ok        = 1'b1;
                n_timer         = '0;
            end
            if (!n_arc_present || !n_torch_out) begin
                n_arc_ok = 1'b0;
            end
            timer_x = {{(ptc_pkg::CMP_W - ptc_pkg::TIMER_WIDTH){1'b0}}, n_timer};
            if (n_arc_ok && timer_x > post_ms) begin
                if (v_s > band_hi) begin
                    n_up   = 1'b0;
                    n_down = 1'b1;
                end else if (v_s < band_lo) begin
                    n_up   = 1'b1;
                    n_down = 1'b0;
                end else begin
                    n_up   = 1'b0;
                    n_down = 1'b0;
                end
            end else begin
                n_up   = 1'b0;
                n_down = 1'b0;
            end
        end else begin
            timer_x     = '0;
            n_torch_out = 1'b0;
            n_up        = 1'b0;
            n_down      = 1'b0;
            n_arc_ok    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer         <= '0;
            r_arc_pin_last  <= 1'b1;
            r_arc_present   <= 1'b0;
            r_arc_from_pin  <= 1'b0;
            r_delay_pending <= 1'b0;
            r_arc_ok        <= 1'b0;
            r_up            <= 1'b0;
            r_down          <= 1'b0;
            r_torch_out     <= 1'b0;
            r_voltage       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_timer         <= n_timer;
                r_arc_pin_last  <= i_head.arc_pin;
                r_arc_present   <= n_arc_present;
                r_arc_from_pin  <= n_arc_from_pin;
                r_delay_pending <= n_delay_pending;
                r_arc_ok        <= n_arc_ok;
                r_up            <= n_up;
                r_down          <= n_down;
                r_torch_out     <= n_torch_out;
                r_voltage       <= n_voltage;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item.torch_drive  <= n_torch_out;
            r_out_item.arc_ok       <= n_arc_ok;
            r_out_item.move_up      <= n_up;
            r_out_item.move_down    <= n_down;
            r_out_item.estop_active <= i_head.estop_pin;
            r_out_item.arc_volts    <= n_voltage;
            r_out_item.arc_detected <= n_arc_present;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### sim/plasma_torch_height_control_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for plasma_torch_height_control: predicts every control pass
// and compares each result item field by field. Depends on ptc_pkg and the block's RTL.

module plasma_torch_height_control_tb;

    localparam int unsigned TIMER_LIMIT = (1 << ptc_pkg::TIMER_WIDTH) - 1;
    localparam int unsigned MS_PER_DECI = 100;
    localparam int unsigned ADC_SEG_A_END = 403;
    localparam int unsigned ADC_SEG_B_END = 830;
    localparam int unsigned SEG_A_OFFSET = 44125389;
    localparam int unsigned SEG_A_SLOPE = 70462;
    localparam int unsigned SEG_B_OFFSET = 24614207;
    localparam int unsigned SEG_B_SLOPE = 22050;
    localparam int unsigned SEG_C_OFFSET = 27629978;
    localparam int unsigned SEG_C_SLOPE = 25369;
    localparam int unsigned ARC_FLOOR_VOLTS = 70;
    localparam logic [ptc_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ptc_pkg::t_in_item in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ptc_pkg::t_out_item out_item;
    logic cfg_we = 1'b0;
    logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ptc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    ptc_pkg::t_out_item due_outputs[$];

    // Predicted copy of the block's registers and control state.
    ptc_pkg::t_cfg settings;
    int unsigned ms_timer;
    logic torch_lvl, arc_pin_prev, arc_on, arc_by_pin, start_wait;
    logic arc_ok_st, up_st, down_st, torch_st, stop_st;
    logic [9:0] volts_st;

    plasma_torch_height_control dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #1_000_000;
        $display("FAIL plasma_torch_height_control");
        $finish;
    end

    function automatic logic [9:0] adc_to_volts(logic [9:0] adc);
        int unsigned ofs, slope, prod, v;
        if (adc < ADC_SEG_A_END) begin
            ofs = SEG_A_OFFSET;
            slope = SEG_A_SLOPE;
        end else if (adc < ADC_SEG_B_END) begin
            ofs = SEG_B_OFFSET;
            slope = SEG_B_SLOPE;
        end else begin
            ofs = SEG_C_OFFSET;
            slope = SEG_C_SLOPE;
        end
        prod = slope * adc;
        v = (prod >= ofs) ? 0 : ((ofs - prod) >> 16);
        if (v < ARC_FLOOR_VOLTS)
            v = 0;
        return v[9:0];
    endfunction

    function automatic ptc_pkg::t_out_item control_pass(ptc_pkg::t_in_item it);
        int unsigned sum;
        logic [9:0] fresh;
        int band_hi, band_lo;
        ptc_pkg::t_out_item res;
        sum = ms_timer + it.elapsed_ms;
        ms_timer = (sum > TIMER_LIMIT) ? TIMER_LIMIT : sum;
        torch_lvl = it.torch_pin;
        if (it.arc_pin != arc_pin_prev) begin
            if (it.arc_pin) begin
                arc_on = 1'b0;
                arc_by_pin = 1'b0;
                start_wait = 1'b0;
            end else if (torch_lvl) begin
                arc_on = 1'b1;
                arc_by_pin = 1'b1;
                start_wait = 1'b1;
                ms_timer = 0;
            end
        end
        arc_pin_prev = it.arc_pin;
        fresh = adc_to_volts(it.adc_sample);
        if (fresh > volts_st || (volts_st - fresh) > settings.refresh_drop)
            volts_st = fresh;
        stop_st = it.estop_pin;
        if (!stop_st) begin
            torch_st = torch_lvl;
            if (!arc_by_pin && torch_lvl) begin
                if (volts_st >= settings.arc_window_low
                        && volts_st <= settings.arc_window_high) begin
                    if (!arc_on) begin
                        arc_on = 1'b1;
                        start_wait = 1'b1;
                        ms_timer = 0;
                    end
                end else if (arc_on) begin
                    arc_on = 1'b0;
                    start_wait = 1'b0;
                end
            end
            if (start_wait && ms_timer > settings.start_delay_tenths * MS_PER_DECI) begin
                start_wait = 1'b0;
                arc_ok_st = 1'b1;
                ms_timer = 0;
            end
            if (!arc_on || !torch_st)
                arc_ok_st = 1'b0;
            up_st = 1'b0;
            down_st = 1'b0;
            if (arc_ok_st && ms_timer > settings.post_delay_tenths * MS_PER_DECI) begin
                band_hi = int'(settings.target_voltage) + int'(settings.hysteresis_volts);
                band_lo = int'(settings.target_voltage) - int'(settings.hysteresis_volts);
                if (int'(volts_st) > band_hi)
                    down_st = 1'b1;
                else if (int'(volts_st) < band_lo)
                    up_st = 1'b1;
            end
        end else begin
            torch_st = 1'b0;
            up_st = 1'b0;
            down_st = 1'b0;
            arc_ok_st = 1'b0;
        end
        res.torch_drive = torch_st;
        res.arc_ok = arc_ok_st;
        res.move_up = up_st;
        res.move_down = down_st;
        res.estop_active = stop_st;
        res.arc_volts = volts_st;
        res.arc_detected = arc_on;
        return res;
    endfunction

    task automatic reset_model();
        settings = '{target_voltage: 10'd140, start_delay_tenths: 8'd10,
                     post_delay_tenths: 8'd10, hysteresis_volts: 8'd3,
                     arc_window_low: 10'd50, arc_window_high: 10'd250,
                     refresh_drop: 8'd2};
        ms_timer = 0;
        torch_lvl = 1'b0;
        arc_pin_prev = 1'b1;
        arc_on = 1'b0;
        arc_by_pin = 1'b0;
        start_wait = 1'b0;
        arc_ok_st = 1'b0;
        up_st = 1'b0;
        down_st = 1'b0;
        torch_st = 1'b0;
        stop_st = 1'b0;
        volts_st = '0;
    endtask

    function automatic ptc_pkg::t_in_item build_pass(logic [7:0] ms, logic [9:0] adc,
                                                     logic torch, logic apin, logic estop);
        ptc_pkg::t_in_item it;
        it.elapsed_ms = ms;
        it.adc_sample = adc;
        it.torch_pin = torch;
        it.arc_pin = apin;
        it.estop_pin = estop;
        return it;
    endfunction

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin : result_check
        ptc_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (due_outputs.size() == 0) begin
                $error("result item with no expected item pending");
                mismatches++;
            end else begin
                want = due_outputs.pop_front();
                check_field("torch_drive", want.torch_drive, out_item.torch_drive);
                check_field("arc_ok", want.arc_ok, out_item.arc_ok);
                check_field("move_up", want.move_up, out_item.move_up);
                check_field("move_down", want.move_down, out_item.move_down);
                check_field("estop_active", want.estop_active, out_item.estop_active);
                check_field("arc_volts", want.arc_volts, out_item.arc_volts);
                check_field("arc_detected", want.arc_detected, out_item.arc_detected);
            end
        end
    end

    task automatic send_pass(ptc_pkg::t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        due_outputs.push_back(control_pass(it));
    endtask

    task automatic wait_for_idle(int settle);
        in_valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_setting(logic [ptc_pkg::CFG_IDX_W-1:0] idx,
                                 logic [ptc_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ptc_pkg::CFG_TARGET_VOLTAGE: settings.target_voltage = val[9:0];
            ptc_pkg::CFG_START_DELAY:    settings.start_delay_tenths = val[7:0];
            ptc_pkg::CFG_POST_DELAY:     settings.post_delay_tenths = val[7:0];
            ptc_pkg::CFG_HYSTERESIS:     settings.hysteresis_volts = val[7:0];
            ptc_pkg::CFG_WINDOW_LOW:     settings.arc_window_low = val[9:0];
            ptc_pkg::CFG_WINDOW_HIGH:    settings.arc_window_high = val[9:0];
            ptc_pkg::CFG_REFRESH_DROP:   settings.refresh_drop = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic pick_settings(logic [9:0] adc_mid);
        int unsigned tgt, spread;
        logic [31:0] rnd_idx;
        tgt = 32'(adc_to_volts(adc_mid));
        if (tgt == 0)
            tgt = $urandom_range(0, 1023);
        spread = $urandom_range(3, 40);
        write_setting(ptc_pkg::CFG_TARGET_VOLTAGE, 10'(tgt));
        write_setting(ptc_pkg::CFG_WINDOW_LOW, 10'((tgt > spread) ? tgt - spread : 0));
        write_setting(ptc_pkg::CFG_WINDOW_HIGH,
                      10'((tgt + spread > 1023) ? 1023 : tgt + spread));
        write_setting(ptc_pkg::CFG_HYSTERESIS, 10'($urandom_range(0, 6)));
        write_setting(ptc_pkg::CFG_START_DELAY, 10'($urandom_range(0, 3)));
        write_setting(ptc_pkg::CFG_POST_DELAY, 10'($urandom_range(0, 3)));
        write_setting(ptc_pkg::CFG_REFRESH_DROP, 10'($urandom_range(0, 4)));
        if ($urandom_range(0, 9) == 0)
            write_setting(ptc_pkg::CFG_START_DELAY, 10'd255);
        if ($urandom_range(0, 5) == 0) begin
            rnd_idx = $urandom_range(0, 7);
            write_setting(rnd_idx[ptc_pkg::CFG_IDX_W-1:0], 10'($urandom()));
        end
    endtask

    // One cut: torch off, arc strike by pin or voltage window, a burn near the
    // setpoint, then torch off again. Unless quiet, noise items and e-stops are mixed in.
    task automatic run_cut(int len, logic [9:0] adc_mid, bit long_ms, bit quiet);
        int k, arc_at, adc;
        bit by_pin;
        logic [31:0] noise;
        ptc_pkg::t_in_item it;
        arc_at = $urandom_range(1, 3);
        by_pin = quiet ? 1'b1 : 1'($urandom_range(0, 1));
        for (k = 0; k < len; k++) begin
            if (!quiet && $urandom_range(0, 99) < 8) begin
                noise = $urandom();
                it = noise[$bits(ptc_pkg::t_in_item)-1:0];
            end else begin
                it.elapsed_ms = long_ms ? 8'($urandom_range(240, 255))
                                        : 8'($urandom_range(0, 120));
                it.torch_pin = (k > 0) && (k < len - 1);
                it.arc_pin = !(by_pin && k >= arc_at && k < len - 1);
                it.estop_pin = !quiet && ($urandom_range(0, 99) < 3);
                if (k < arc_at) begin
                    adc = $urandom_range(900, 1023);
                end else begin
                    adc = int'(adc_mid) + int'($urandom_range(0, 24)) - 12;
                    if (adc < 0)
                        adc = 0;
                    if (adc > 1023)
                        adc = 1023;
                end
                it.adc_sample = 10'(adc);
            end
            send_pass(it);
        end
    endtask

    task automatic test_voltage_map();
        logic [9:0] probes [8] = '{10'd0, 10'd402, 10'd403, 10'd829, 10'd830,
                                   10'd1023, 10'h2AA, 10'h155};
        int k;
        for (k = 0; k < 8; k++)
            send_pass(build_pass((k % 2) ? 8'd255 : 8'd0, probes[k], 1'b0, 1'b1, 1'b0));
    endtask

    task automatic test_arc_sequence();
        logic [9:0] tgt;
        tgt = adc_to_volts(10'd600);
        wait_for_idle(3);
        write_setting(ptc_pkg::CFG_START_DELAY, 10'd0);
        write_setting(ptc_pkg::CFG_POST_DELAY, 10'd0);
        write_setting(ptc_pkg::CFG_HYSTERESIS, 10'd2);
        write_setting(ptc_pkg::CFG_TARGET_VOLTAGE, tgt);
        write_setting(ptc_pkg::CFG_WINDOW_LOW, tgt - 10'd20);
        write_setting(ptc_pkg::CFG_WINDOW_HIGH, tgt + 10'd20);
        write_setting(ptc_pkg::CFG_REFRESH_DROP, 10'd2);
        send_pass(build_pass(8'd10, 10'd1023, 1'b1, 1'b1, 1'b0));
        send_pass(build_pass(8'd5, 10'd1023, 1'b1, 1'b0, 1'b0));
        send_pass(build_pass(8'd7, 10'd1023, 1'b1, 1'b0, 1'b0));
        send_pass(build_pass(8'd1, 10'd560, 1'b1, 1'b0, 1'b0));
        send_pass(build_pass(8'd3, 10'd640, 1'b1, 1'b0, 1'b0));
        send_pass(build_pass(8'd3, 10'd601, 1'b1, 1'b0, 1'b0));
        send_pass(build_pass(8'd2, 10'd601, 1'b1, 1'b1, 1'b0));
        send_pass(build_pass(8'd2, 10'd601, 1'b0, 1'b0, 1'b0));
        send_pass(build_pass(8'd4, 10'd601, 1'b1, 1'b1, 1'b1));
        send_pass(build_pass(8'd4, 10'd601, 1'b1, 1'b1, 1'b0));
    endtask

    task automatic test_register_extremes();
        wait_for_idle(3);
        write_setting(ptc_pkg::CFG_TARGET_VOLTAGE, 10'd0);
        write_setting(ptc_pkg::CFG_HYSTERESIS, 10'd255);
        write_setting(ptc_pkg::CFG_WINDOW_LOW, 10'd0);
        write_setting(ptc_pkg::CFG_WINDOW_HIGH, 10'd1023);
        write_setting(ptc_pkg::CFG_START_DELAY, 10'd0);
        write_setting(ptc_pkg::CFG_POST_DELAY, 10'd0);
        write_setting(ptc_pkg::CFG_REFRESH_DROP, 10'd0);
        send_pass(build_pass(8'd0, 10'd1023, 1'b1, 1'b1, 1'b0));
        send_pass(build_pass(8'd9, 10'd1023, 1'b1, 1'b1, 1'b0));
        send_pass(build_pass(8'd9, 10'd0, 1'b1, 1'b1, 1'b0));
        send_pass(build_pass(8'd9, 10'd700, 1'b1, 1'b1, 1'b0));
        wait_for_idle(3);
        write_setting(ptc_pkg::CFG_TARGET_VOLTAGE, 10'd1023);
        write_setting(ptc_pkg::CFG_HYSTERESIS, 10'd0);
        write_setting(ptc_pkg::CFG_WINDOW_LOW, 10'd600);
        write_setting(ptc_pkg::CFG_WINDOW_HIGH, 10'd100);
        write_setting(ptc_pkg::CFG_REFRESH_DROP, 10'd255);
        write_setting(CFG_IDX_UNUSED, 10'($urandom()));
        send_pass(build_pass(8'd255, 10'd700, 1'b1, 1'b1, 1'b0));
        send_pass(build_pass(8'd255, 10'd0, 1'b1, 1'b1, 1'b0));
        send_pass(build_pass(8'd255, 10'd900, 1'b1, 1'b1, 1'b0));
    endtask

    task automatic test_random_cuts(int unsigned quota);
        int unsigned sent;
        int len, pick;
        logic [9:0] mid;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                mid = 10'($urandom_range(404, 829));
            else if (pick < 9)
                mid = 10'($urandom_range(0, 402));
            else
                mid = 10'($urandom_range(830, 1023));
            len = $urandom_range(6, 40);
            wait_for_idle(3);
            pick_settings(mid);
            run_cut(len, mid, $urandom_range(0, 9) == 0, 1'b0);
            sent += len;
        end
    endtask

    // A burn long enough for the millisecond timer to reach its ceiling.
    task automatic test_timer_saturation();
        logic [9:0] mid;
        mid = 10'($urandom_range(450, 780));
        wait_for_idle(3);
        pick_settings(mid);
        write_setting(ptc_pkg::CFG_START_DELAY, 10'd0);
        write_setting(ptc_pkg::CFG_POST_DELAY, 10'd255);
        run_cut(300, mid, 1'b1, 1'b1);
    endtask

    initial begin
        reset_model();
        send_idle_pct = 24;
        recv_stall_pct = 79;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_voltage_map();
        test_arc_sequence();
        test_register_extremes();
        test_random_cuts(270);
        wait_for_idle(3);
        send_idle_pct = 79;
        recv_stall_pct = 24;
        test_random_cuts(270);
        wait_for_idle(3);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_cuts(260);
        test_timer_saturation();
        wait_for_idle(8);
        if (mismatches == 0)
            $display("PASS plasma_torch_height_control");
        else
            $display("FAIL plasma_torch_height_control");
        $finish;
    end

endmodule
